>>> sv/vfc_pkg.sv
// shared types, constants and helpers of the view frustum culler
// no dependencies
package vfc_pkg;

  localparam int FRAC_BITS_DEF   = 16;
  localparam int PLANE_COUNT_DEF = 6;
  localparam int PLANE_IDX_W     = 3;
  localparam int EPS_W           = 16;
  localparam int ACC_W           = 68;

  typedef enum logic [1:0] {
    MODE_LOAD   = 2'd0,
    MODE_BUILD  = 2'd1,
    MODE_SPHERE = 2'd2,
    MODE_BOX    = 2'd3
  } mode_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ROW,
    OP_ACC_CLR,
    OP_MUL_SQ,
    OP_MUL_DOT,
    OP_ACC,
    OP_SQRT_GO,
    OP_DIV_GO,
    OP_DIV_WR,
    OP_EVAL,
    OP_EMIT
  } dp_op_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_ROW,
    S_SQ_CLR,
    S_SQ_MUL,
    S_SQ_ACC,
    S_SQRT_GO,
    S_SQRT_WAIT,
    S_CHECK,
    S_DIV_GO,
    S_DIV_WAIT,
    S_DIV_WR,
    S_DOT_CLR,
    S_DOT_MUL,
    S_DOT_ACC,
    S_EVAL,
    S_EMIT
  } ctrl_state_e;

  typedef struct packed {
    dp_op_e                 op;
    logic                   capture;
    logic [PLANE_IDX_W-1:0] plane;
    logic [1:0]             comp;
  } dp_cmd_t;

  typedef struct packed {
    logic sqrt_busy;
    logic div_busy;
    logic len_ok;
  } dp_status_t;

  // magnitude of a signed 32-bit word, exact for the most negative value
  function automatic logic [31:0] mag32(input logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  // saturate a 33-bit signed sum to 32 bits
  function automatic logic [31:0] sat33(input logic [32:0] s);
    if (s[32] != s[31]) return s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    return s[31:0];
  endfunction

endpackage

>>> sv/view_frustum_culler.sv
// top level of the view frustum culler: sequencer plus datapath
// depends on vfc_pkg, vfc_ctrl, vfc_dp
//
// A request is taken when start is high and busy is low; busy stays high
// until the request is done. A load request writes one matrix element and
// finishes in the accepting cycle. A sphere request or box corner runs the
// six planes through one shared multiply-accumulate; a box corner that is
// not the last one gives no result. A build request first steps the four
// rows, then per plane sums the squares, takes the square root, checks the
// length and, when the plane is normalized, runs 4 divisions, at Q16.16 by
// default; the square root and the divider are bit-serial. Results appear
// on result_strobe_o for one cycle and cannot be stalled. The epsilon
// register is always ready.
module view_frustum_culler #(
  parameter int FRAC_BITS   = vfc_pkg::FRAC_BITS_DEF,
  parameter int PLANE_COUNT = vfc_pkg::PLANE_COUNT_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                mode_i,
  input  logic [1:0]                row_i,
  input  logic [1:0]                col_i,
  input  logic signed [31:0]        value_i,
  input  logic signed [31:0]        px_i,
  input  logic signed [31:0]        py_i,
  input  logic signed [31:0]        pz_i,
  input  logic [30:0]               radius_i,
  input  logic                      last_corner_i,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [vfc_pkg::EPS_W-1:0] cfg_data_i,
  output logic                      result_strobe_o,
  output logic                      visible_o,
  output logic                      test_kind_o
);
  import vfc_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // epsilon writes land whenever offered
  assign cfg_ready_o = 1'b1;

  vfc_ctrl #(.PLANE_COUNT(PLANE_COUNT)) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .mode_i        (mode_i),
    .last_corner_i (last_corner_i),
    .status_i      (status),
    .cmd_o         (cmd)
  );

  vfc_dp #(.FRAC_BITS(FRAC_BITS), .PLANE_COUNT(PLANE_COUNT)) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_data_i      (cfg_data_i),
    .mode_i          (mode_i),
    .row_i           (row_i),
    .col_i           (col_i),
    .value_i         (value_i),
    .px_i            (px_i),
    .py_i            (py_i),
    .pz_i            (pz_i),
    .radius_i        (radius_i),
    .result_strobe_o (result_strobe_o),
    .visible_o       (visible_o),
    .test_kind_o     (test_kind_o)
  );

endmodule

>>> sv/vfc_ctrl.sv
// sequencer of the view frustum culler: walks rows, planes and components
// depends on vfc_pkg
module vfc_ctrl #(
  parameter int PLANE_COUNT = vfc_pkg::PLANE_COUNT_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          mode_i,
  input  logic                last_corner_i,
  input  vfc_pkg::dp_status_t status_i,
  output vfc_pkg::dp_cmd_t    cmd_o
);
  import vfc_pkg::*;

  localparam logic [PLANE_IDX_W-1:0] LastPlane = PLANE_IDX_W'(PLANE_COUNT - 1);

  ctrl_state_e            state_q, state_d;
  logic [PLANE_IDX_W-1:0] plane_q, plane_d;
  logic [1:0]             comp_q, comp_d;
  mode_e                  mode_q, mode_d;
  logic                   last_q, last_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      plane_q <= '0;
      comp_q  <= '0;
      mode_q  <= MODE_LOAD;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      plane_q <= plane_d;
      comp_q  <= comp_d;
      mode_q  <= mode_d;
      last_q  <= last_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    plane_d       = plane_q;
    comp_d        = comp_q;
    mode_d        = mode_q;
    last_d        = last_q;
    cmd_o.op      = OP_NONE;
    cmd_o.capture = 1'b0;
    cmd_o.plane   = plane_q;
    cmd_o.comp    = comp_q;
    busy          = (state_q != S_IDLE);
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.capture = 1'b1;
          mode_d        = mode_e'(mode_i);
          last_d        = last_corner_i;
          plane_d       = '0;
          comp_d        = '0;
          case (mode_e'(mode_i))
            MODE_LOAD:   state_d = S_IDLE;
            MODE_BUILD:  state_d = S_ROW;
            default:     state_d = S_DOT_CLR;
          endcase
        end
      end
      S_ROW: begin
        cmd_o.op = OP_ROW;
        comp_d   = comp_q + 2'd1;
        if (comp_q == 2'd3) state_d = S_SQ_CLR;
      end
      S_SQ_CLR: begin
        cmd_o.op = OP_ACC_CLR;
        comp_d   = '0;
        state_d  = S_SQ_MUL;
      end
      S_SQ_MUL: begin
        cmd_o.op = OP_MUL_SQ;
        state_d  = S_SQ_ACC;
      end
      S_SQ_ACC: begin
        cmd_o.op = OP_ACC;
        if (comp_q == 2'd2) begin
          comp_d  = '0;
          state_d = S_SQRT_GO;
        end else begin
          comp_d  = comp_q + 2'd1;
          state_d = S_SQ_MUL;
        end
      end
      S_SQRT_GO: begin
        cmd_o.op = OP_SQRT_GO;
        state_d  = S_SQRT_WAIT;
      end
      S_SQRT_WAIT: begin
        if (!status_i.sqrt_busy) state_d = S_CHECK;
      end
      S_CHECK: begin
        if (status_i.len_ok) begin
          state_d = S_DIV_GO;
        end else if (plane_q == LastPlane) begin
          state_d = S_IDLE;
        end else begin
          plane_d = plane_q + 1'b1;
          state_d = S_SQ_CLR;
        end
      end
      S_DIV_GO: begin
        cmd_o.op = OP_DIV_GO;
        state_d  = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (!status_i.div_busy) state_d = S_DIV_WR;
      end
      S_DIV_WR: begin
        cmd_o.op = OP_DIV_WR;
        comp_d   = comp_q + 2'd1;
        if (comp_q != 2'd3) begin
          state_d = S_DIV_GO;
        end else if (plane_q == LastPlane) begin
          state_d = S_IDLE;
        end else begin
          plane_d = plane_q + 1'b1;
          state_d = S_SQ_CLR;
        end
      end
      S_DOT_CLR: begin
        cmd_o.op = OP_ACC_CLR;
        comp_d   = '0;
        state_d  = S_DOT_MUL;
      end
      S_DOT_MUL: begin
        cmd_o.op = OP_MUL_DOT;
        state_d  = S_DOT_ACC;
      end
      S_DOT_ACC: begin
        cmd_o.op = OP_ACC;
        comp_d   = comp_q + 2'd1;
        state_d  = (comp_q == 2'd3) ? S_EVAL : S_DOT_MUL;
      end
      S_EVAL: begin
        cmd_o.op = OP_EVAL;
        if (plane_q != LastPlane) begin
          plane_d = plane_q + 1'b1;
          state_d = S_DOT_CLR;
        end else if (mode_q == MODE_SPHERE || last_q) begin
          state_d = S_EMIT;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_EMIT: begin
        cmd_o.op = OP_EMIT;
        state_d  = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

>>> sv/vfc_dp.sv
// datapath of the view frustum culler: stores, multiplier, accumulator,
// square root and divider units; depends on vfc_pkg
module vfc_dp #(
  parameter int FRAC_BITS   = vfc_pkg::FRAC_BITS_DEF,
  parameter int PLANE_COUNT = vfc_pkg::PLANE_COUNT_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  vfc_pkg::dp_cmd_t           cmd_i,
  output vfc_pkg::dp_status_t        status_o,
  input  logic                       cfg_valid_i,
  input  logic [vfc_pkg::EPS_W-1:0]  cfg_data_i,
  input  logic [1:0]                 mode_i,
  input  logic [1:0]                 row_i,
  input  logic [1:0]                 col_i,
  input  logic signed [31:0]         value_i,
  input  logic signed [31:0]         px_i,
  input  logic signed [31:0]         py_i,
  input  logic signed [31:0]         pz_i,
  input  logic [30:0]                radius_i,
  output logic                       result_strobe_o,
  output logic                       visible_o,
  output logic                       test_kind_o
);
  import vfc_pkg::*;

  localparam int NUM_W = 32 + FRAC_BITS;
  localparam int DCNT_W = $clog2(NUM_W + 1);

  logic [31:0] mat_q [4][4];            // [col][row]
  logic [31:0] plane_q [PLANE_COUNT][4];
  logic [PLANE_COUNT-1:0] box_q;
  logic        sph_vis_q;
  logic [EPS_W-1:0] eps_q;
  mode_e       mode_q;
  logic signed [31:0] pt_q [3];
  logic [30:0] rad_q;

  logic signed [65:0]      prod_q;
  logic signed [ACC_W-1:0] acc_q;

  logic [63:0] sq_q;
  logic [34:0] srem_q;
  logic [31:0] root_q;
  logic [5:0]  scnt_q;

  logic [NUM_W-1:0]  num_q;
  logic [31:0]       drem_q;
  logic [NUM_W-1:0]  quo_q;
  logic [DCNT_W-1:0] dcnt_q;

  logic [31:0] cur;
  logic signed [32:0] op_a, op_b;
  logic [1:0]  r;

  assign cur = plane_q[cmd_i.plane][cmd_i.comp];
  assign r   = cmd_i.comp;

  always_comb begin
    op_a = $signed({cur[31], cur});
    case (cmd_i.comp)
      2'd0:    op_b = $signed({pt_q[0][31], pt_q[0]});
      2'd1:    op_b = $signed({pt_q[1][31], pt_q[1]});
      2'd2:    op_b = $signed({pt_q[2][31], pt_q[2]});
      default: op_b = $signed(33'(1) << FRAC_BITS);
    endcase
    if (cmd_i.op == OP_MUL_SQ) begin
      op_a = $signed({1'b0, mag32(cur)});
      op_b = $signed({1'b0, mag32(cur)});
    end
  end

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) eps_q <= EPS_W'(1);
    else if (cfg_valid_i) eps_q <= cfg_data_i;
  end

  // capture of the accepted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_LOAD;
      for (int c = 0; c < 4; c++)
        for (int k = 0; k < 4; k++) mat_q[c][k] <= '0;
    end else if (cmd_i.capture) begin
      mode_q <= mode_e'(mode_i);
      if (mode_e'(mode_i) == MODE_LOAD) mat_q[col_i][row_i] <= value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      pt_q[0] <= px_i;
      pt_q[1] <= py_i;
      pt_q[2] <= pz_i;
      rad_q   <= radius_i;
    end
  end

  // multiplier and accumulator
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_MUL_SQ || cmd_i.op == OP_MUL_DOT) prod_q <= op_a * op_b;
    if (cmd_i.op == OP_ACC_CLR) begin
      if (mode_q == MODE_SPHERE) acc_q <= $signed(ACC_W'(rad_q) << FRAC_BITS);
      else acc_q <= '0;
    end else if (cmd_i.op == OP_ACC) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
  end

  // square root, one result bit per cycle
  logic [34:0] srem_n, strial;
  assign srem_n = {srem_q[32:0], sq_q[63:62]};
  assign strial = {1'b0, root_q, 2'b01};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scnt_q <= '0;
    end else if (cmd_i.op == OP_SQRT_GO) begin
      scnt_q <= 6'd32;
    end else if (scnt_q != 6'd0) begin
      scnt_q <= scnt_q - 6'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_SQRT_GO) begin
      sq_q   <= acc_q[63:0];
      srem_q <= '0;
      root_q <= '0;
    end else if (scnt_q != 6'd0) begin
      sq_q <= {sq_q[61:0], 2'b00};
      if (srem_n >= strial) begin
        srem_q <= srem_n - strial;
        root_q <= {root_q[30:0], 1'b1};
      end else begin
        srem_q <= srem_n;
        root_q <= {root_q[30:0], 1'b0};
      end
    end
  end

  // restoring divider, one quotient bit per cycle
  logic [32:0] drem_n;
  assign drem_n = {drem_q, num_q[NUM_W-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dcnt_q <= '0;
    end else if (cmd_i.op == OP_DIV_GO) begin
      dcnt_q <= DCNT_W'(NUM_W);
    end else if (dcnt_q != '0) begin
      dcnt_q <= dcnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_DIV_GO) begin
      num_q  <= NUM_W'(mag32(cur)) << FRAC_BITS;
      drem_q <= '0;
      quo_q  <= '0;
    end else if (dcnt_q != '0) begin
      num_q <= num_q << 1;
      if (drem_n >= {1'b0, root_q}) begin
        drem_q <= 32'(drem_n - {1'b0, root_q});
        quo_q  <= {quo_q[NUM_W-2:0], 1'b1};
      end else begin
        drem_q <= drem_n[31:0];
        quo_q  <= {quo_q[NUM_W-2:0], 1'b0};
      end
    end
  end

  logic        q_big;
  logic [31:0] norm_val;
  assign q_big = |quo_q[NUM_W-1:31];
  always_comb begin
    if (!cur[31]) norm_val = q_big ? 32'h7FFF_FFFF : quo_q[31:0];
    else          norm_val = q_big ? 32'h8000_0000 : (~quo_q[31:0] + 32'd1);
  end

  // plane store: row builds and normalized writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < PLANE_COUNT; p++)
        for (int c = 0; c < 4; c++) plane_q[p][c] <= '0;
    end else if (cmd_i.op == OP_ROW) begin
      plane_q[0][r] <= sat33({mat_q[3][r][31], mat_q[3][r]} + {mat_q[0][r][31], mat_q[0][r]});
      plane_q[1][r] <= sat33({mat_q[3][r][31], mat_q[3][r]} - {mat_q[0][r][31], mat_q[0][r]});
      plane_q[2][r] <= sat33({mat_q[3][r][31], mat_q[3][r]} + {mat_q[1][r][31], mat_q[1][r]});
      plane_q[3][r] <= sat33({mat_q[3][r][31], mat_q[3][r]} - {mat_q[1][r][31], mat_q[1][r]});
      plane_q[4][r] <= mat_q[2][r];
      plane_q[5][r] <= sat33({mat_q[3][r][31], mat_q[3][r]} - {mat_q[2][r][31], mat_q[2][r]});
    end else if (cmd_i.op == OP_DIV_WR) begin
      plane_q[cmd_i.plane][cmd_i.comp] <= norm_val;
    end
  end

  // test flags and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_q           <= '1;
      sph_vis_q       <= 1'b1;
      result_strobe_o <= 1'b0;
      visible_o       <= 1'b0;
      test_kind_o     <= 1'b0;
    end else begin
      result_strobe_o <= 1'b0;
      if (cmd_i.capture && mode_e'(mode_i) == MODE_SPHERE) sph_vis_q <= 1'b1;
      if (cmd_i.op == OP_EVAL && acc_q[ACC_W-1] && mode_q == MODE_SPHERE)
        sph_vis_q <= 1'b0;
      if (cmd_i.op == OP_EVAL && !acc_q[ACC_W-1] && mode_q == MODE_BOX)
        box_q[cmd_i.plane] <= 1'b0;
      if (cmd_i.op == OP_EMIT) begin
        result_strobe_o <= 1'b1;
        if (mode_q == MODE_SPHERE) begin
          visible_o   <= sph_vis_q;
          test_kind_o <= 1'b0;
        end else begin
          visible_o   <= (box_q == '0);
          test_kind_o <= 1'b1;
          box_q       <= '1;
        end
      end
    end
  end

  assign status_o.sqrt_busy = (scnt_q != 6'd0);
  assign status_o.div_busy  = (dcnt_q != '0);
  assign status_o.len_ok    = (root_q != 32'd0) && (root_q >= 32'(eps_q));

endmodule

>>> test/testbench.sv
// self-checking testbench for view_frustum_culler: directed and random requests
// predicts sphere and box results with its own frustum model; depends on vfc_pkg
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import vfc_pkg::*;

  localparam int FRAC = 16;
  localparam int CYCLE_LIMIT = 10_000_000;
  // drain wait, long enough for a build request with every plane normalized
  localparam int BUILD_CYCLES = 1600;

  typedef struct packed {
    logic visible;
    logic test_kind;
  } cull_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] mode_i = '0;
  logic [1:0] row_i = '0;
  logic [1:0] col_i = '0;
  logic signed [31:0] value_i = '0;
  logic signed [31:0] px_i = '0;
  logic signed [31:0] py_i = '0;
  logic signed [31:0] pz_i = '0;
  logic [30:0] radius_i = '0;
  logic last_corner_i = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [EPS_W-1:0] cfg_data_i = '0;
  logic result_strobe_o;
  logic visible_o;
  logic test_kind_o;

  view_frustum_culler i_dut (
    .clk_i, .rst_ni, .start, .busy, .mode_i, .row_i, .col_i, .value_i,
    .px_i, .py_i, .pz_i, .radius_i, .last_corner_i, .cfg_valid_i, .cfg_ready_o,
    .cfg_data_i, .result_strobe_o, .visible_o, .test_kind_o
  );

  always #1 clk_i = ~clk_i;

  // predictor state, updated as each request is accepted
  logic [31:0] matrix_q[16];
  logic [31:0] plane_q[24];
  logic [5:0] box_neg_q;
  logic [15:0] epsilon_q;

  cull_result_t cull_expected[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left = 0;

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    mismatch_count++;
  endtask

  // saturate a wide signed value to a 32-bit word
  function automatic logic [31:0] sat_word(input longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint sword(input logic [31:0] w);
    return longint'($signed(w));
  endfunction

  function automatic logic [63:0] magnitude(input longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  // extract the six planes and normalize each one whose length is usable
  function automatic void rebuild_planes();
    longint c0, c1, c2, c3, v;
    logic [63:0] sq, len, q, m;
    for (int r = 0; r < 4; r++) begin
      c0 = sword(matrix_q[r*4+0]);
      c1 = sword(matrix_q[r*4+1]);
      c2 = sword(matrix_q[r*4+2]);
      c3 = sword(matrix_q[r*4+3]);
      plane_q[0*4+r] = sat_word(c3 + c0);
      plane_q[1*4+r] = sat_word(c3 - c0);
      plane_q[2*4+r] = sat_word(c3 + c1);
      plane_q[3*4+r] = sat_word(c3 - c1);
      plane_q[4*4+r] = sat_word(c2);
      plane_q[5*4+r] = sat_word(c3 - c2);
    end
    for (int p = 0; p < 6; p++) begin
      sq = 0;
      for (int c = 0; c < 3; c++) begin
        m = magnitude(sword(plane_q[p*4+c]));
        sq = sq + m * m;
      end
      len = int_sqrt(sq);
      if (len == 0 || len < 64'(epsilon_q)) continue;
      for (int c = 0; c < 4; c++) begin
        v = sword(plane_q[p*4+c]);
        q = (magnitude(v) << FRAC) / len;
        if (q > (64'd1 << 32)) q = 64'd1 << 32;
        plane_q[p*4+c] = v < 0 ? sat_word(-longint'(q)) : sat_word(longint'(q));
      end
    end
  endfunction

  // exact sign of plane dot (x,y,z,1) plus an extra term at double fraction
  function automatic logic below_plane(input int p, input logic [31:0] x,
                                       input logic [31:0] y, input logic [31:0] z,
                                       input longint extra);
    logic signed [71:0] acc;
    longint t;
    acc = {{8{extra[63]}}, extra};
    t = sword(plane_q[p*4+0]) * sword(x);
    acc = acc + {{8{t[63]}}, t};
    t = sword(plane_q[p*4+1]) * sword(y);
    acc = acc + {{8{t[63]}}, t};
    t = sword(plane_q[p*4+2]) * sword(z);
    acc = acc + {{8{t[63]}}, t};
    t = sword(plane_q[p*4+3]) << FRAC;
    acc = acc + {{8{t[63]}}, t};
    return acc < 0;
  endfunction

  // apply one accepted request to the predictor, queue its result if any
  function automatic void predict_request(input mode_e m, input logic [1:0] r,
      input logic [1:0] c, input logic [31:0] val, input logic [31:0] x,
      input logic [31:0] y, input logic [31:0] z, input logic [30:0] rad,
      input logic last);
    cull_result_t res;
    logic [5:0] neg;
    case (m)
      MODE_LOAD: matrix_q[r*4+c] = val;
      MODE_BUILD: rebuild_planes();
      MODE_SPHERE: begin
        res.visible = 1'b1;
        res.test_kind = 1'b0;
        for (int p = 0; p < 6; p++)
          if (below_plane(p, x, y, z, longint'(rad) << FRAC)) res.visible = 1'b0;
        cull_expected.push_back(res);
      end
      default: begin
        neg = '0;
        for (int p = 0; p < 6; p++) neg[p] = below_plane(p, x, y, z, 0);
        box_neg_q = box_neg_q & neg;
        if (last) begin
          res.visible = (box_neg_q == 0);
          res.test_kind = 1'b1;
          cull_expected.push_back(res);
          box_neg_q = '1;
        end
      end
    endcase
  endfunction

  // drive one request, wait for acceptance, then maybe leave a sender gap
  task automatic send_request(input mode_e m, input logic [1:0] r, input logic [1:0] c,
      input logic [31:0] val, input logic [31:0] x, input logic [31:0] y,
      input logic [31:0] z, input logic [30:0] rad, input logic last);
    start <= 1'b1;
    mode_i <= m;
    row_i <= r;
    col_i <= c;
    value_i <= val;
    px_i <= x;
    py_i <= y;
    pz_i <= z;
    radius_i <= rad;
    last_corner_i <= last;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predict_request(m, r, c, val, x, y, z, rad, last);
    if (burst_left == 0) begin
      // end of burst: drop start for a random gap, sometimes a long run of none
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 8);
    end else begin
      burst_left--;
    end
  endtask

  // wait until the block is quiet, including a build that emits nothing
  task automatic drain_block();
    start <= 1'b0;
    while (cull_expected.size() != 0) @(posedge clk_i);
    repeat (BUILD_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_epsilon(input logic [15:0] eps);
    drain_block();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= eps;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    epsilon_q = eps;
    cfg_valid_i <= 1'b0;
  endtask

  // mostly small coordinates (within about +-8), sometimes the full range
  function automatic logic [31:0] rand_coord();
    if ($urandom_range(0, 4) == 0) return $urandom;
    return 32'($urandom_range(0, 32'h10_0000)) - 32'h8_0000;
  endfunction

  function automatic logic [31:0] rand_element();
    if ($urandom_range(0, 9) == 0) return $urandom;
    return 32'($urandom_range(0, 32'h4_0000)) - 32'h2_0000;
  endfunction

  function automatic logic [30:0] rand_radius();
    if ($urandom_range(0, 4) == 0) return 31'($urandom);
    return 31'($urandom_range(0, 32'h4_0000));
  endfunction

  task automatic send_load(input logic [1:0] r, input logic [1:0] c, input logic [31:0] v);
    send_request(MODE_LOAD, r, c, v, $urandom, $urandom, $urandom, 31'($urandom),
                 1'($urandom));
  endtask

  task automatic send_build();
    send_request(MODE_BUILD, 2'($urandom), 2'($urandom), $urandom, $urandom,
                 $urandom, $urandom, 31'($urandom), 1'($urandom));
  endtask

  task automatic send_sphere(input logic [31:0] x, input logic [31:0] y,
                             input logic [31:0] z, input logic [30:0] rad);
    send_request(MODE_SPHERE, 2'($urandom), 2'($urandom), $urandom, x, y, z, rad,
                 1'($urandom));
  endtask

  task automatic send_corner(input logic [31:0] x, input logic [31:0] y,
                             input logic [31:0] z, input logic last);
    send_request(MODE_BOX, 2'($urandom), 2'($urandom), $urandom, x, y, z,
                 31'($urandom), last);
  endtask

  task automatic load_random_matrix();
    for (int e = 0; e < 16; e++) send_load(2'(e / 4), 2'(e % 4), rand_element());
    send_build();
  endtask

  // zero planes after reset, then saturating sums and extreme points
  task automatic test_extremes();
    send_build();
    send_sphere(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 31'h0);
    send_corner(32'h0, 32'h0, 32'h0, 1'b1);
    send_load(2'd0, 2'd0, 32'h8000_0000);
    send_load(2'd0, 2'd3, 32'h8000_0000);
    send_load(2'd1, 2'd1, 32'h7FFF_FFFF);
    send_load(2'd1, 2'd3, 32'h7FFF_FFFF);
    send_load(2'd2, 2'd2, 32'h0001_0000);
    send_load(2'd3, 2'd3, 32'h0001_0000);
    send_load(2'd3, 2'd0, 32'hFFFF_FFFF);
    send_build();
    send_sphere(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
    send_sphere(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h0);
    send_sphere(32'h0, 32'h0, 32'h0, 31'h1);
    send_corner(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    send_corner(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
    send_corner(32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000, 1'b1);
    // box with one corner, and a box split by other requests
    send_corner(32'h8000_0000, 32'h0, 32'h0, 1'b1);
    send_corner(32'h0010_0000, 32'h0, 32'h0, 1'b0);
    send_sphere(32'h0, 32'h0, 32'h0, 31'h7FFF_FFFF);
    send_corner(32'h0020_0000, 32'h0, 32'h0, 1'b1);
  endtask

  // epsilon extremes change which planes stay unnormalized
  task automatic test_epsilon();
    logic [15:0] eps_list[4];
    eps_list = '{16'd0, 16'hFFFF, 16'($urandom), 16'd1};
    foreach (eps_list[i]) begin
      write_epsilon(eps_list[i]);
      load_random_matrix();
      repeat (4) send_sphere(rand_coord(), rand_coord(), rand_coord(), rand_radius());
    end
  endtask

  // random traffic: matrix reloads, single loads, builds, spheres and boxes of mostly eight corners
  task automatic test_random_traffic(input int unsigned item_goal);
    int unsigned sent;
    int unsigned corners;
    logic [31:0] cx, cy, cz, ex, ey, ez;
    bit paused;
    sent = 0;
    paused = 0;
    while (sent < item_goal) begin
      if (!paused && sent > item_goal / 2) begin
        // hold off until every expected result has come back
        start <= 1'b0;
        while (cull_expected.size() != 0) @(posedge clk_i);
        paused = 1;
      end
      case ($urandom_range(0, 19))
        0: begin
          load_random_matrix();
          sent += 17;
        end
        1: begin
          send_load(2'($urandom), 2'($urandom), rand_element());
          sent++;
        end
        2: begin
          send_build();
          sent++;
        end
        3, 4, 5, 6, 7, 8, 9: begin
          send_sphere(rand_coord(), rand_coord(), rand_coord(), rand_radius());
          sent++;
        end
        default: begin
          // axis-aligned box around a random center; now and then a broken count
          cx = rand_coord();
          cy = rand_coord();
          cz = rand_coord();
          ex = $urandom_range(0, 32'h2_0000);
          ey = $urandom_range(0, 32'h2_0000);
          ez = $urandom_range(0, 32'h2_0000);
          corners = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 12) : 8;
          for (int k = 0; k < corners; k++) begin
            send_corner(k[0] ? cx + ex : cx - ex, k[1] ? cy + ey : cy - ey,
                        k[2] ? cz + ez : cz - ez, k == corners - 1);
            sent++;
          end
        end
      endcase
    end
  endtask

  // result checker: the receiver cannot stall, so sample every strobe
  always @(posedge clk_i) begin
    cull_result_t exp_res;
    if (rst_ni && result_strobe_o) begin
      if (cull_expected.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        exp_res = cull_expected.pop_front();
        if (visible_o !== exp_res.visible)
          report_mismatch($sformatf("visible %b, expected %b", visible_o, exp_res.visible));
        if (test_kind_o !== exp_res.test_kind)
          report_mismatch($sformatf("test_kind %b, expected %b", test_kind_o,
                                    exp_res.test_kind));
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    foreach (matrix_q[i]) matrix_q[i] = '0;
    foreach (plane_q[i]) plane_q[i] = '0;
    box_neg_q = '1;
    epsilon_q = 16'd1;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_epsilon();
    test_random_traffic(650);
    drain_block();
    if (cull_expected.size() == 0 && mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
